FILE: rtl/thms_pkg.sv
// Shared constants and helper functions for the text header message segmenter.
// Used by thms_total_conv, thms_emitter and text_header_message_segmenter.
// No dependencies.
package thms_pkg;

   localparam int CHUNK_BYTES_DEF = 64;
   localparam int LEN_W           = 16;
   localparam int BCD_DIGITS      = 5;
   localparam int BCD_W           = 4 * BCD_DIGITS;
   localparam int TX_W            = 4;
   localparam int POS_W           = 3;

   localparam logic [TX_W-1:0] TX_LAST     = 4'd9;
   localparam logic [7:0]      ASCII_ZERO  = 8'h30;
   localparam logic [7:0]      ASCII_COMMA = 8'h2C;
   localparam logic [7:0]      ASCII_NL    = 8'h0A;

   // Command codes on the input channel
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // One data transaction's worth of framing work, handed to the emitter
   typedef struct packed {
      logic [TX_W-1:0]  tx_digit;
      logic [BCD_W-1:0] index_bcd;
      logic [BCD_W-1:0] total_bcd;
      logic [7:0]       data_byte;
      logic             header;
      logic             newline;
   } thms_item_type;

   // Decimal increment of a five digit BCD word, wrapping each digit at ten
   function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] b);
      logic [BCD_W-1:0] r;
      logic             carry;
      logic [4:0]       d;
      r     = '0;
      carry = 1'b1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = {1'b0, b[4*i +: 4]} + {4'd0, carry};
         if (d >= 5'd10) begin
            r[4*i +: 4] = 4'd0;
            carry       = 1'b1;
         end else begin
            r[4*i +: 4] = d[3:0];
            carry       = 1'b0;
         end
      end
      return r;
   endfunction

   // Position of the most significant non-zero digit, zero when all digits are zero
   function automatic logic [POS_W-1:0] bcd_top(input logic [BCD_W-1:0] b);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (b[4*i +: 4] != 4'd0) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   // Digit at a given position
   function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] b,
                                            input logic [POS_W-1:0] pos);
      logic [3:0] d;
      d = 4'd0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (pos == POS_W'(i)) begin
            d = b[4*i +: 4];
         end
      end
      return d;
   endfunction

   // ASCII character of a digit, codes above nine print as nine
   function automatic logic [7:0] ascii_digit(input logic [3:0] d);
      logic [3:0] s;
      s = (d > 4'd9) ? 4'd9 : d;
      return ASCII_ZERO + {4'd0, s};
   endfunction

endpackage

FILE: rtl/thms_total_conv.sv
// Packet total unit: ceiling division of the message length by the chunk size,
// then binary to BCD conversion, one bit per cycle. Depends on thms_pkg.
module thms_total_conv
   import thms_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LEN_W-1:0] length,
   output logic             busy,
   output logic [BCD_W-1:0] total_bcd
);

   // Reciprocal for the constant divide: exact for a 17 bit numerator and
   // divisors up to 1024
   localparam int X_W         = $clog2(2 ** LEN_W + CHUNK_BYTES - 1);
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = X_W + RECIP_W;
   localparam int DAB_W       = BCD_W + LEN_W;
   localparam int CNT_W       = $clog2(LEN_W);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_MUL  = 2'd1;
   localparam logic [1:0] C_DAB  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DAB_W-1:0] dab_ff, dab_in;
   logic [PROD_W-1:0] prod;
   logic [DAB_W-1:0]  adj;

   // Product of the rounded-up length and the reciprocal
   assign prod = PROD_W'(x_ff) * PROD_W'(RECIP);

   // Add three to every BCD digit of five or more before the shift
   always_comb begin
      adj = dab_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (dab_ff[LEN_W + 4*i +: 4] >= 4'd5) begin
            adj[LEN_W + 4*i +: 4] = dab_ff[LEN_W + 4*i +: 4] + 4'd3;
         end
      end
   end

   // Sequencer: capture, multiply, then one shift-and-adjust step per cycle
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      cnt_in   = cnt_ff;
      dab_in   = dab_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = X_W'(length) + X_W'(CHUNK_BYTES - 1);
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            dab_in   = {{BCD_W{1'b0}}, prod[RECIP_SHIFT +: LEN_W]};
            cnt_in   = '0;
            state_in = C_DAB;
         end
         C_DAB: begin
            dab_in = {adj[DAB_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LEN_W - 1)) begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
         dab_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dab_ff   <= dab_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign busy      = (state_ff != C_IDLE);
   assign total_bcd = dab_ff[DAB_W-1 -: BCD_W];

endmodule

FILE: rtl/thms_emitter.sv
// Output sequencer: walks one data transaction's optional header, payload byte and
// optional newline out on the result channel, one character a beat. Depends on thms_pkg.
module thms_emitter
   import thms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  thms_item_type item,
   output logic          free,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // [7:0] out_char
   output logic          rsp_tuser,   // [0] packet_end
   output logic          rsp_tlast    // run_last
);

   localparam logic [2:0] P_TX   = 3'd0;
   localparam logic [2:0] P_C1   = 3'd1;
   localparam logic [2:0] P_IDX  = 3'd2;
   localparam logic [2:0] P_C2   = 3'd3;
   localparam logic [2:0] P_TOT  = 3'd4;
   localparam logic [2:0] P_C3   = 3'd5;
   localparam logic [2:0] P_BYTE = 3'd6;
   localparam logic [2:0] P_NL   = 3'd7;

   logic             busy_ff, busy_in;
   logic [2:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   thms_item_type    item_ff, item_in;
   logic             beat_done;
   logic             last;

   assign last      = (phase_ff == P_NL) || ((phase_ff == P_BYTE) && !item_ff.newline);
   assign beat_done = busy_ff && rsp_tready;
   assign free      = !busy_ff || (beat_done && last);

   // Character of the current beat
   always_comb begin
      unique case (phase_ff)
         P_TX:    rsp_tdata = ascii_digit(item_ff.tx_digit);
         P_IDX:   rsp_tdata = ascii_digit(bcd_digit(item_ff.index_bcd, pos_ff));
         P_TOT:   rsp_tdata = ascii_digit(bcd_digit(item_ff.total_bcd, pos_ff));
         P_BYTE:  rsp_tdata = item_ff.data_byte;
         P_NL:    rsp_tdata = ASCII_NL;
         default: rsp_tdata = ASCII_COMMA;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = (phase_ff == P_NL);
   assign rsp_tlast  = last;

   // Phase sequencing on each taken beat; a new transaction loads as the last beat leaves
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      item_in  = item_ff;
      if (beat_done) begin
         unique case (phase_ff)
            P_TX: phase_in = P_C1;
            P_C1: phase_in = P_IDX;
            P_IDX: begin
               if (pos_ff == '0) begin
                  phase_in = P_C2;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
            P_C2: begin
               phase_in = P_TOT;
               pos_in   = bcd_top(item_ff.total_bcd);
            end
            P_TOT: begin
               if (pos_ff == '0) begin
                  phase_in = P_C3;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
            P_C3:   phase_in = P_BYTE;
            P_BYTE: phase_in = P_NL;
            P_NL:   phase_in = P_TX;
            default: phase_in = P_TX;
         endcase
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         item_in  = item;
         phase_in = item.header ? P_TX : P_BYTE;
         pos_in   = bcd_top(item.index_bcd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= P_TX;
         pos_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // A packet-closing newline always ends the transaction's results
   a_nl_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("newline beat not marked last");

   // The newline phase is reached only for a transaction that closes a packet
   a_nl_wanted: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (phase_ff == P_NL) |-> item_ff.newline)
      else $error("newline emitted for a transaction without one");

   // Digit position stays within the five BCD digits
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(BCD_DIGITS - 1))
      else $error("digit position out of range");

endmodule

FILE: rtl/text_header_message_segmenter.sv
// Top level of the text header message segmenter: message state, packet
// counting and handshake. Depends on thms_pkg, thms_total_conv, thms_emitter.
//
//   Channel | Direction | Ports              | Carries
//   req     | in        | tvalid tready      | tuser = command,
//           |           | tdata tuser        | tdata = message_length, data_byte
//   rsp     | out       | tvalid tready      | tdata = out_char, tuser = packet_end,
//           |           | tdata tuser tlast  | tlast = run_last
//
// A begin transaction starts the packet total unit; req_tready stays low for
// all of its multiply and 16 shift steps.
// A data transaction gives 1 or 2 result beats, 7 to 16 when it opens a chunk;
// the sequencer gives one beat a cycle while rsp_tready is high, and the next
// request is taken in the cycle the last beat of the previous one is taken.
// A dropped byte or a begin is taken once the sequencer is free.
// Synchronous active-high reset clears all message state; rsp_tready low simply
// holds the current beat.
module text_header_message_segmenter
   import thms_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] message_length, [23:16] data_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tuser,   // [0] packet_end
   output logic        rsp_tlast
);

   localparam int OFF_W = $clog2(CHUNK_BYTES + 1);

   logic [TX_W-1:0]  next_tx_ff, next_tx_in;
   logic [TX_W-1:0]  msg_tx_ff, msg_tx_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [BCD_W-1:0] index_ff, index_in;

   logic             accept;
   logic             is_begin;
   logic             conv_busy;
   logic [BCD_W-1:0] total_bcd;
   logic             emit_free;
   logic             load;
   thms_item_type    item;
   logic [OFF_W-1:0] offset_next;
   logic [LEN_W-1:0] remaining_next;
   logic             closes;

   assign req_tready = !conv_busy && emit_free;
   assign accept     = req_tvalid && req_tready;
   assign is_begin   = (req_tuser == CMD_BEGIN);

   // Byte accounting for a data transaction
   assign offset_next    = offset_ff + 1'b1;
   assign remaining_next = remaining_ff - 1'b1;
   assign closes         = (offset_next == OFF_W'(CHUNK_BYTES)) || (remaining_next == '0);
   assign load           = accept && !is_begin && (remaining_ff != '0);

   always_comb begin
      item.tx_digit  = msg_tx_ff;
      item.index_bcd = index_ff;
      item.total_bcd = total_bcd;
      item.data_byte = req_tdata[23:16];
      item.header    = (offset_ff == '0);
      item.newline   = closes;
   end

   // Message state update
   always_comb begin
      next_tx_in   = next_tx_ff;
      msg_tx_in    = msg_tx_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      index_in     = index_ff;
      if (accept && is_begin) begin
         msg_tx_in    = next_tx_ff;
         next_tx_in   = (next_tx_ff >= TX_LAST) ? '0 : next_tx_ff + 1'b1;
         remaining_in = req_tdata[15:0];
         offset_in    = '0;
         index_in     = '0;
      end else if (load) begin
         remaining_in = remaining_next;
         if (closes) begin
            offset_in = '0;
            index_in  = bcd_inc(index_ff);
         end else begin
            offset_in = offset_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_tx_ff   <= '0;
         msg_tx_ff    <= '0;
         remaining_ff <= '0;
         offset_ff    <= '0;
         index_ff     <= '0;
      end else begin
         next_tx_ff   <= next_tx_in;
         msg_tx_ff    <= msg_tx_in;
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
         index_ff     <= index_in;
      end
   end

   thms_total_conv #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_total_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && is_begin),
      .length    (req_tdata[15:0]),
      .busy      (conv_busy),
      .total_bcd (total_bcd)
   );

   thms_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .item       (item),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // No request is taken while the packet total is being worked out
   a_conv_blocks: assert property (@(posedge clock) disable iff (reset)
      conv_busy |-> !req_tready)
      else $error("request taken during total conversion");

   // Chunk offset never reaches the chunk size
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff < OFF_W'(CHUNK_BYTES))
      else $error("chunk offset out of range");

   // Transaction digit stays decimal
   a_tx_range: assert property (@(posedge clock) disable iff (reset)
      next_tx_ff <= TX_LAST && msg_tx_ff <= TX_LAST)
      else $error("transaction digit out of range");

endmodule
